### hdl/lpfm_pkg.sv
// ----------------------------------------------------------------------------
// lpfm_pkg
// Shared types and constants of the LRU page-frame mapper: request and
// response words, field widths, default sizes and an elaboration-time helper.
// ----------------------------------------------------------------------------
package lpfm_pkg;

  localparam int DEF_FRAMES            = 256;
  localparam int DEF_PROCESSES         = 32;
  localparam int DEF_PAGES_PER_PROCESS = 32;

  localparam int PROC_IDX_W = 5;
  localparam int ADDR_W     = 15;
  localparam int SEC_W      = 32;
  localparam int NSEC_W     = 30;
  localparam int FRAME_NUM_W = 8;

  // 1024-byte pages
  localparam int PAGE_SHIFT = 10;
  localparam int PAGE_IDX_W = ADDR_W - PAGE_SHIFT;
  localparam int LAST_USE_W = SEC_W + NSEC_W;

  localparam int PROC_CODES = 2 ** PROC_IDX_W;
  localparam int PAGE_CODES = 2 ** PAGE_IDX_W;

  typedef struct packed {
    logic [PROC_IDX_W-1:0] process_index;
    logic [ADDR_W-1:0]     address;
    logic                  is_write;
    logic [SEC_W-1:0]      time_seconds;
    logic [NSEC_W-1:0]     time_nanoseconds;
  } lpfm_req_t;

  typedef struct packed {
    logic [FRAME_NUM_W-1:0] frame_number;
    logic                   page_fault;
  } lpfm_rsp_t;

  // Remainder by repeated subtraction; used only on constants at elaboration.
  function automatic int wrap_code(int value, int modulus);
    int r;
    r = value;
    while (r >= modulus) r = r - modulus;
    return r;
  endfunction

endpackage

### hdl/lpfm_page_map.sv
// ----------------------------------------------------------------------------
// lpfm_page_map
// Page table memory of all processes: one entry per (process, page) slot
// holding a valid bit and a frame number. Sweeps every entry to invalid after
// reset and reports ready once the sweep is done.
// ----------------------------------------------------------------------------
module lpfm_page_map
  import lpfm_pkg::*;
#(
  parameter int SLOTS = DEF_PROCESSES * DEF_PAGES_PER_PROCESS,
  parameter int FW    = $clog2(DEF_FRAMES),
  parameter int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [SW-1:0] rd_slot,
  output logic          rd_valid,
  output logic [FW-1:0] rd_frame,
  input  logic          wr_en,
  input  logic [SW-1:0] wr_slot,
  input  logic          wr_valid,
  input  logic [FW-1:0] wr_frame,
  output logic          ready
);

  logic [FW:0]   mem [SLOTS];
  logic [FW:0]   rd_q;
  logic          clearing;
  logic [SW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == SW'(SLOTS - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_slot] <= {wr_valid, wr_frame};
    end
    if (rd_en) begin
      rd_q <= mem[rd_slot];
    end
  end

  assign rd_valid = rd_q[FW];
  assign rd_frame = rd_q[FW-1:0];
  assign ready    = !clearing;

endmodule

### hdl/lru_page_frame_mapper.sv
// ----------------------------------------------------------------------------
// lru_page_frame_mapper
// Maps process page accesses onto a shared pool of frames with least
// recently used replacement.
// ----------------------------------------------------------------------------
// One access is handled at a time. After reset the page table is swept to
// invalid, one entry per cycle, during which no access is taken. A hit, and
// a fault while free frames remain, pass from accept to response through
// page table read, frame table read, update and response. Frames are filled
// in index order, so a fill count stands for the occupied flags. Once every
// frame is in use a fault reads the whole frame table through its single
// read port, one frame a cycle, to find the oldest last-use time. The
// response sits in an output register, and the next access may be accepted
// while it waits to be taken.
// ----------------------------------------------------------------------------
module lru_page_frame_mapper
  import lpfm_pkg::*;
#(
  parameter int FRAMES            = DEF_FRAMES,
  parameter int PROCESSES         = DEF_PROCESSES,
  parameter int PAGES_PER_PROCESS = DEF_PAGES_PER_PROCESS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  lpfm_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output lpfm_rsp_t rsp
);

  localparam int SLOTS = PROCESSES * PAGES_PER_PROCESS;
  localparam int FW    = $clog2(FRAMES);
  localparam int PW    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int PGW   = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic [PW-1:0]         owner;
    logic [PGW-1:0]        page;
    logic                  dirty;
    logic [LAST_USE_W-1:0] last_use;
  } frame_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_FRAME,
    S_SCAN,
    S_EVICT,
    S_INSTALL,
    S_DONE
  } state_t;

  state_t state;

  // Wrap tables for out-of-range process and page codes
  logic [PW-1:0]  proc_wrap [PROC_CODES];
  logic [PGW-1:0] page_wrap [PAGE_CODES];

  for (genvar i = 0; i < PROC_CODES; i++) begin : g_proc_wrap
    assign proc_wrap[i] = PW'(wrap_code(i, PROCESSES));
  end
  for (genvar i = 0; i < PAGE_CODES; i++) begin : g_page_wrap
    assign page_wrap[i] = PGW'(wrap_code(i, PAGES_PER_PROCESS));
  end

  logic                  accept;
  logic [PW-1:0]         req_proc;
  logic [PGW-1:0]        req_page;
  logic [SW-1:0]         req_slot;

  logic [PW-1:0]         cur_proc;
  logic [PGW-1:0]        cur_page;
  logic [SW-1:0]         cur_slot;
  logic                  cur_wr;
  logic [LAST_USE_W-1:0] cur_now;

  logic [FW:0]           fill_cnt;
  logic                  full;
  logic [FW-1:0]         res_frame;
  logic                  res_fault;

  logic [FW-1:0]         scan_iss;
  logic [FW-1:0]         scan_rcv;
  logic                  scan_take;
  logic                  scan_last;
  logic [FW-1:0]         best_frame;
  logic [LAST_USE_W-1:0] best_lu;
  logic [PW-1:0]         best_owner;
  logic [PGW-1:0]        best_page;
  logic [SW-1:0]         old_slot;

  // page table port
  logic                  pm_ready;
  logic                  pm_rd_valid;
  logic [FW-1:0]         pm_rd_frame;
  logic                  pm_we;
  logic [SW-1:0]         pm_wslot;
  logic                  pm_wvalid;
  logic [FW-1:0]         pm_wframe;

  // frame table memory
  frame_entry_t          fmem [FRAMES];
  frame_entry_t          fr_q;
  logic                  fr_re;
  logic [FW-1:0]         fr_raddr;
  logic                  fr_we;
  logic [FW-1:0]         fr_waddr;
  frame_entry_t          fr_wdata;
  logic                  hit;

  assign req_stall = !(state == S_IDLE && pm_ready);
  assign accept    = req_valid && !req_stall;

  assign req_proc = proc_wrap[req.process_index];
  assign req_page = page_wrap[req.address[ADDR_W-1:PAGE_SHIFT]];
  assign req_slot = SW'(SW'(req_proc) * SW'(PAGES_PER_PROCESS)) + SW'(req_page);
  assign old_slot = SW'(SW'(best_owner) * SW'(PAGES_PER_PROCESS)) + SW'(best_page);

  assign full = (fill_cnt == (FW + 1)'(FRAMES));

  // A stale entry (frame free or held by another page) counts as a miss
  assign hit = pm_rd_valid && ({1'b0, pm_rd_frame} < fill_cnt) &&
               (fr_q.owner == cur_proc) && (fr_q.page == cur_page);

  assign scan_take = (scan_rcv == '0) || (fr_q.last_use < best_lu);
  assign scan_last = (scan_rcv == FW'(FRAMES - 1));

  lpfm_page_map #(
    .SLOTS (SLOTS),
    .FW    (FW),
    .SW    (SW)
  ) u_page_map (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_slot  (req_slot),
    .rd_valid (pm_rd_valid),
    .rd_frame (pm_rd_frame),
    .wr_en    (pm_we),
    .wr_slot  (pm_wslot),
    .wr_valid (pm_wvalid),
    .wr_frame (pm_wframe),
    .ready    (pm_ready)
  );

  always_comb begin
    fr_re     = 1'b0;
    fr_raddr  = pm_rd_frame;
    fr_we     = 1'b0;
    fr_waddr  = pm_rd_frame;
    fr_wdata  = '{owner: cur_proc, page: cur_page, dirty: cur_wr, last_use: cur_now};
    pm_we     = 1'b0;
    pm_wslot  = cur_slot;
    pm_wvalid = 1'b1;
    pm_wframe = fill_cnt[FW-1:0];
    unique case (state)
      S_MAP: begin
        fr_re = 1'b1;
      end
      S_FRAME: begin
        if (hit) begin
          // refresh time, keep dirty sticky
          fr_we    = 1'b1;
          fr_wdata = '{owner: fr_q.owner, page: fr_q.page,
                       dirty: fr_q.dirty | cur_wr, last_use: cur_now};
        end else if (!full) begin
          fr_we    = 1'b1;
          fr_waddr = fill_cnt[FW-1:0];
          pm_we    = 1'b1;
        end else begin
          fr_re    = 1'b1;
          fr_raddr = '0;
        end
      end
      S_SCAN: begin
        fr_re    = !scan_last;
        fr_raddr = scan_iss;
      end
      S_EVICT: begin
        // drop the victim's old mapping, install the new owner
        fr_we     = 1'b1;
        fr_waddr  = best_frame;
        pm_we     = 1'b1;
        pm_wslot  = old_slot;
        pm_wvalid = 1'b0;
        pm_wframe = '0;
      end
      S_INSTALL: begin
        pm_we     = 1'b1;
        pm_wframe = best_frame;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fr_we) begin
      fmem[fr_waddr] <= fr_wdata;
    end
    if (fr_re) begin
      fr_q <= fmem[fr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // drop a taken word unless the next one loads this cycle
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_proc <= req_proc;
            cur_page <= req_page;
            cur_slot <= req_slot;
            cur_wr   <= req.is_write;
            cur_now  <= {req.time_seconds, req.time_nanoseconds};
            state    <= S_MAP;
          end
        end
        S_MAP: begin
          state <= S_FRAME;
        end
        S_FRAME: begin
          if (hit) begin
            res_frame <= pm_rd_frame;
            res_fault <= 1'b0;
            state     <= S_DONE;
          end else if (!full) begin
            res_frame <= fill_cnt[FW-1:0];
            res_fault <= 1'b1;
            fill_cnt  <= fill_cnt + 1'b1;
            state     <= S_DONE;
          end else begin
            scan_iss <= FW'(1);
            scan_rcv <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // strict less-than keeps the lowest index on ties
          if (scan_take) begin
            best_frame <= scan_rcv;
            best_lu    <= fr_q.last_use;
            best_owner <= fr_q.owner;
            best_page  <= fr_q.page;
          end
          if (scan_last) begin
            state <= S_EVICT;
          end else begin
            scan_rcv <= scan_iss;
            scan_iss <= scan_iss + 1'b1;
          end
        end
        S_EVICT: begin
          state <= S_INSTALL;
        end
        S_INSTALL: begin
          res_frame <= best_frame;
          res_fault <= 1'b1;
          state     <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp_valid || !rsp_stall) begin
            rsp.frame_number <= FRAME_NUM_W'(res_frame);
            rsp.page_fault   <= res_fault;
            rsp_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
